// File: src/ptm_pkg.sv
package ptm_pkg;

   localparam int IDX_W     = 9;
   localparam int VPN_W     = 36;
   localparam int FRAME_W   = 40;
   localparam int FLAGS_W   = 4;
   localparam int CMD_W     = 3;
   localparam int STATUS_W  = 2;
   localparam int LEVELS    = 4;
   localparam int ENTRIES   = 512;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_TRANSLATE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_MAP       = 3'd1;
   localparam logic [CMD_W-1:0] CMD_UNMAP     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET_PERMS = 3'd3;
   localparam logic [CMD_W-1:0] CMD_GET_PERMS = 3'd4;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_MAPPED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED  = 2'd2;

   // Flags of a freshly created intermediate entry: writable and user.
   localparam logic [FLAGS_W-1:0] TABLE_FLAGS = 4'b0011;

   // One table entry, 45 bits: flags on top, then present, then frame.
   typedef struct packed {
      logic [FLAGS_W-1:0] flags;
      logic               present;
      logic [FRAME_W-1:0] frame;
   } entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FRAME_W-1:0]  frame_out;
      logic [FLAGS_W-1:0]  perm_out;
      logic                leaf_present;
   } result_type;

   // Table index for a walk level; level 0 is the root.
   function automatic logic [IDX_W-1:0] level_index(input logic [VPN_W-1:0] vpn,
                                                    input logic [1:0] lvl);
      logic [IDX_W-1:0] idx;
      case (lvl)
         2'd0:    idx = vpn[35:27];
         2'd1:    idx = vpn[26:18];
         2'd2:    idx = vpn[17:9];
         default: idx = vpn[8:0];
      endcase
      return idx;
   endfunction

endpackage

// File: src/ptm_req_if.sv
interface ptm_req_if;
   import ptm_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [VPN_W-1:0]   virt_page;
   logic [FRAME_W-1:0] phys_page;
   logic [FLAGS_W-1:0] perm_bits;

   modport source (output valid, command, virt_page, phys_page, perm_bits, input ready);
   modport sink   (input valid, command, virt_page, phys_page, perm_bits, output ready);
endinterface

// File: src/ptm_rsp_if.sv
interface ptm_rsp_if;
   import ptm_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [FRAME_W-1:0]  frame_out;
   logic [FLAGS_W-1:0]  perm_out;
   logic                leaf_present;

   modport source (output valid, status, frame_out, perm_out, leaf_present, input ready);
   modport sink   (input valid, status, frame_out, perm_out, leaf_present, output ready);
endinterface

// File: src/four_level_page_table_manager_unit.sv
// Channel   Dir  Handshake      Payload
// req_chan  in   valid/ready    command, virt_page, phys_page, perm_bits
// rsp_chan  out  valid/ready    status, frame_out, perm_out, leaf_present
//
// A walk reads one level per pass through S_READ and S_EVAL, issuing the read in S_READ and using
// the registered data in S_EVAL; a miss ends the walk early. After reset a clearing pass zeroes
// all TABLE_PAGES * 512 entries, one per cycle, and no transfer is accepted until it ends. A
// finished result waits in an output register while the next command runs, which then stalls
// until that result drains.
module four_level_page_table_manager_unit #(
   parameter int TABLE_PAGES = 64
) (
   input logic       clock,
   input logic       reset,
   ptm_req_if.sink   req_chan,
   ptm_rsp_if.source rsp_chan
);
   import ptm_pkg::*;

   localparam int PageW  = $clog2(TABLE_PAGES);
   localparam int AddrW  = PageW + IDX_W;
   localparam int Depth  = TABLE_PAGES * ENTRIES;
   localparam int CountW = $clog2(TABLE_PAGES + 1);

   // One-hot sequencer states.
   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_READ  = 7'b0000100,
      S_EVAL  = 7'b0001000,
      S_ALLOC = 7'b0010000,
      S_LEAF  = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [VPN_W-1:0]   vpn_ff, vpn_in;
   logic [FRAME_W-1:0] ppn_ff, ppn_in;
   logic [FLAGS_W-1:0] perm_ff, perm_in;
   logic [1:0]         lvl_ff, lvl_in;
   logic [PageW-1:0]   page_ff, page_in;
   logic [CountW-1:0]  next_free_ff, next_free_in;
   logic [AddrW-1:0]   clr_ff, clr_in;
   entry_type          leaf_ff, leaf_in;
   result_type         res_ff, res_in;
   result_type         rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // The table memory: one write and one registered read per cycle.
   entry_type          table_mem_ff [Depth];
   entry_type          rd_data_ff;
   logic               mem_we;
   logic [AddrW-1:0]   mem_wa;
   entry_type          mem_wd;
   logic [AddrW-1:0]   cur_addr;

   // Walk decode of the entry just read.
   logic               ent_ok;
   logic               at_leaf;
   logic [CountW-1:0]  avail;
   logic [CountW-1:0]  need;
   logic               rsp_load;

   // Every access of a command targets the entry of the current page at the current level.
   // Reads and writes of one command never overlap in time, and a command starts only after
   // the previous one has written back, so no forwarding is needed.
   assign cur_addr = {page_ff, level_index(vpn_ff, lvl_ff)};

   assign ent_ok  = rd_data_ff.present && (rd_data_ff.frame < FRAME_W'(TABLE_PAGES));
   assign at_leaf = (lvl_ff == 2'd3);
   assign avail   = CountW'(TABLE_PAGES) - next_free_ff;
   assign need    = CountW'(2'd3 - lvl_ff);

   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem_ff[mem_wa] <= mem_wd;
      end
      rd_data_ff <= table_mem_ff[cur_addr];
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = cur_addr;
      mem_wd = leaf_ff;
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
         end
         S_ALLOC: begin
            // Link the missing table to the next free page.
            mem_we        = 1'b1;
            mem_wd.flags   = TABLE_FLAGS;
            mem_wd.present = 1'b1;
            mem_wd.frame   = FRAME_W'(next_free_ff);
         end
         S_LEAF: begin
            mem_we = 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      vpn_in       = vpn_ff;
      ppn_in       = ppn_ff;
      perm_in      = perm_ff;
      lvl_in       = lvl_ff;
      page_in      = page_ff;
      next_free_in = next_free_ff;
      clr_in       = clr_ff;
      leaf_in      = leaf_ff;
      res_in       = res_ff;

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + AddrW'(1);
            if (clr_ff == AddrW'(Depth - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in  = req_chan.command;
               vpn_in  = req_chan.virt_page;
               ppn_in  = req_chan.phys_page;
               perm_in = req_chan.perm_bits;
               lvl_in  = 2'd0;
               page_in = '0;
               res_in  = '0;
               // Undefined command codes answer with an all-zero result.
               if (req_chan.command inside {CMD_TRANSLATE, CMD_MAP, CMD_UNMAP,
                                            CMD_SET_PERMS, CMD_GET_PERMS}) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            res_in = '0;
            if (!at_leaf && ent_ok) begin
               // Descend into the next table.
               page_in  = rd_data_ff.frame[PageW-1:0];
               lvl_in   = lvl_ff + 2'd1;
               state_in = S_READ;
            end else if (!at_leaf) begin
               // A level is missing; only map may build it, and only if enough pages remain.
               state_in = S_RESP;
               if (cmd_ff == CMD_MAP) begin
                  if (need > avail) begin
                     res_in.status = STATUS_EXHAUSTED;
                  end else begin
                     state_in = S_ALLOC;
                     leaf_in  = '{flags: perm_ff, present: 1'b1, frame: ppn_ff};
                     res_in   = '{status: STATUS_OK, frame_out: ppn_ff, perm_out: perm_ff,
                                  leaf_present: 1'b1};
                  end
               end else begin
                  res_in.status = STATUS_NOT_MAPPED;
               end
            end else begin
               // Leaf entry reached.
               leaf_in  = rd_data_ff;
               state_in = S_RESP;
               res_in.leaf_present = rd_data_ff.present;
               res_in.perm_out     = rd_data_ff.flags;
               res_in.frame_out    = rd_data_ff.present ? rd_data_ff.frame : '0;
               case (cmd_ff)
                  CMD_MAP: begin
                     leaf_in  = '{flags: perm_ff, present: 1'b1, frame: ppn_ff};
                     res_in   = '{status: STATUS_OK, frame_out: ppn_ff, perm_out: perm_ff,
                                  leaf_present: 1'b1};
                     state_in = S_LEAF;
                  end
                  CMD_UNMAP: begin
                     leaf_in.present     = 1'b0;
                     res_in.leaf_present = 1'b0;
                     res_in.frame_out    = '0;
                     state_in            = S_LEAF;
                  end
                  CMD_SET_PERMS: begin
                     leaf_in.flags   = perm_ff;
                     res_in.perm_out = perm_ff;
                     state_in        = S_LEAF;
                  end
                  CMD_TRANSLATE: begin
                     res_in.status = rd_data_ff.present ? STATUS_OK : STATUS_NOT_MAPPED;
                  end
                  default: begin
                     res_in.status = STATUS_OK;
                  end
               endcase
            end
         end
         S_ALLOC: begin
            // One new table per cycle, the new page is already zero from the clearing pass.
            page_in      = next_free_ff[PageW-1:0];
            next_free_in = next_free_ff + CountW'(1);
            lvl_in       = lvl_ff + 2'd1;
            if (lvl_ff == 2'd2) begin
               state_in = S_LEAF;
            end
         end
         S_LEAF: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (rsp_load) begin
         rsp_data_in  = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         next_free_ff <= CountW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         next_free_ff <= next_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      vpn_ff      <= vpn_in;
      ppn_ff      <= ppn_in;
      perm_ff     <= perm_in;
      lvl_ff      <= lvl_in;
      page_ff     <= page_in;
      leaf_ff     <= leaf_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_data_ff.status;
   assign rsp_chan.frame_out    = rsp_data_ff.frame_out;
   assign rsp_chan.perm_out     = rsp_data_ff.perm_out;
   assign rsp_chan.leaf_present = rsp_data_ff.leaf_present;

endmodule

// File: src/ptm_checker.sv
module ptm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [ptm_pkg::STATUS_W-1:0]   status,
   input logic [ptm_pkg::FRAME_W-1:0]    frame_out,
   input logic [ptm_pkg::FLAGS_W-1:0]    perm_out,
   input logic                           leaf_present
);
   import ptm_pkg::*;

   // The result register comes out of reset empty.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Commands are worked one at a time: no transfer right after a transfer.
   assert property (@(posedge clock) disable iff (reset)
                    req_valid && req_ready |=> !req_ready)
      else $error("input taken while a command is in progress");

   // Status code three is never produced.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid |-> (status == STATUS_OK || status == STATUS_NOT_MAPPED ||
                                   status == STATUS_EXHAUSTED))
      else $error("undefined status code");

   // A failed command never reports a frame.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && status != STATUS_OK |-> frame_out == '0)
      else $error("frame reported with a failing status");

   // A result that is held back stays as it is.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
                    $stable(frame_out) && $stable(perm_out) && $stable(leaf_present))
      else $error("stalled result changed");

endmodule

bind four_level_page_table_manager_unit ptm_checker u_ptm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .status       (rsp_chan.status),
   .frame_out    (rsp_chan.frame_out),
   .perm_out     (rsp_chan.perm_out),
   .leaf_present (rsp_chan.leaf_present)
);

// File: verif/tb_four_level_page_table_manager_unit.sv
`timescale 1ns / 1ps

// Self-checking bench for the four-level page table manager.
//
// A queue of commands is built up front: a short directed opening, then random
// commands that mostly land on a small set of hot virtual regions, so that
// tables get reused and leaves get mapped, unmapped and re-flagged many times.
// A thin stream of noise commands with fully random addresses uses up the
// table store part way through the run, so that maps start to fail with the
// store exhausted.
//
// The driver and the monitor are clocked processes. On every request transfer
// the driver runs the command through the bench's own model of the table
// store and queues the expected response. The monitor compares every response
// transfer field by field against the oldest queued expectation.
module tb_four_level_page_table_manager_unit;
   import ptm_pkg::*;

   localparam int TABLE_PAGES    = 64;
   localparam int RANDOM_ITEMS   = 680;
   // No idling on either side over the last stretch of the run.
   localparam int QUIET_TAIL     = 80;
   // After this many request transfers the sender waits for every response.
   localparam int DRAIN_AT       = 400;
   // After this many response transfers the receiver holds off for a long
   // stretch while the sender keeps offering, so the block backs up.
   localparam int HOLD_AT        = 150;
   localparam int HOLD_CYCLES    = 300;
   // The clearing pass after reset alone zeroes all TABLE_PAGES * 512 entries.
   localparam int WATCHDOG_LIMIT = 4 * TABLE_PAGES * ENTRIES;
   localparam int SETTLE_CYCLES  = 40;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [VPN_W-1:0]   virt_page;
      logic [FRAME_W-1:0] phys_page;
      logic [FLAGS_W-1:0] perm_bits;
   } table_cmd_type;

   logic clock;
   logic reset;

   ptm_req_if req_if ();
   ptm_rsp_if rsp_if ();

   four_level_page_table_manager_unit #(
      .TABLE_PAGES(TABLE_PAGES)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if.sink),
      .rsp_chan(rsp_if.source)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Model of the table store and the bump allocator of table pages.
   entry_type   page_mem [TABLE_PAGES*ENTRIES];
   int unsigned next_free_page;

   table_cmd_type pending_cmds [$];
   result_type    expected_results [$];

   // Hot regions: two choices at each of the three upper levels.
   logic [IDX_W-1:0] hot_root [2];
   logic [IDX_W-1:0] hot_mid [2];
   logic [IDX_W-1:0] hot_low [2];

   int total_items;
   int accepted_cnt;
   int received_cnt;
   int error_count;
   int idle_cycles;

   // Driver state.
   table_cmd_type offered;
   logic          offering;
   int            gap_left;
   logic          gaps_on;

   // Monitor state.
   result_type got;
   result_type want;
   logic       ready_next;
   int         stall_left;
   int         hold_left;
   logic       stalls_on;

   // Applies one command to the model and returns the response it must give.
   // The walk stops at the first intermediate entry that is not present or
   // that names a page outside the store; found is the number of levels
   // passed, three when the leaf table was reached.
   function automatic result_type apply_command(input table_cmd_type cmd);
      logic [IDX_W-1:0] idx [LEVELS];
      int unsigned page;
      int unsigned slot;
      int unsigned new_page;
      int unsigned tables_needed;
      int unsigned tables_left;
      int          found;
      int          lvl;
      entry_type   e;
      result_type  r;

      r     = '0;
      page  = 0;
      slot  = 0;
      found = 3;
      for (lvl = 0; lvl < LEVELS; lvl++) begin
         idx[lvl] = cmd.virt_page[VPN_W-1-IDX_W*lvl -: IDX_W];
      end

      // Reserved command codes are answered with an all-zero response.
      if (cmd.command > CMD_GET_PERMS) begin
         return r;
      end

      for (lvl = 0; lvl < 3; lvl++) begin
         if (found == 3) begin
            e = page_mem[page*ENTRIES + idx[lvl]];
            if (!e.present || e.frame >= TABLE_PAGES) begin
               found = lvl;
            end else begin
               page = 32'(e.frame);
            end
         end
      end
      if (found == 3) begin
         slot = page*ENTRIES + idx[3];
      end

      if (cmd.command == CMD_MAP) begin
         // A map is all or nothing: if the missing tables do not all fit,
         // the store is left as it was.
         tables_needed = 3 - found;
         tables_left   = (next_free_page < TABLE_PAGES) ? TABLE_PAGES - next_free_page : 0;
         if (tables_needed > tables_left) begin
            r.status = STATUS_EXHAUSTED;
         end else begin
            for (lvl = found; lvl < 3; lvl++) begin
               new_page       = next_free_page;
               next_free_page = next_free_page + 1;
               for (int i = 0; i < ENTRIES; i++) begin
                  page_mem[new_page*ENTRIES + i] = '0;
               end
               e.flags   = TABLE_FLAGS;
               e.present = 1'b1;
               e.frame   = FRAME_W'(new_page);
               page_mem[page*ENTRIES + idx[lvl]] = e;
               page = new_page;
            end
            slot      = page*ENTRIES + idx[3];
            e.flags   = cmd.perm_bits;
            e.present = 1'b1;
            e.frame   = cmd.phys_page;
            page_mem[slot] = e;
            found = 3;
         end
      end else if (found < 3) begin
         r.status = STATUS_NOT_MAPPED;
      end else if (cmd.command == CMD_UNMAP) begin
         page_mem[slot].present = 1'b0;
      end else if (cmd.command == CMD_SET_PERMS) begin
         page_mem[slot].flags = cmd.perm_bits;
      end

      // Once the leaf table is reached the response reports the leaf as it
      // stands after the command; a translate of an absent leaf still fails.
      if (r.status != STATUS_EXHAUSTED && found == 3) begin
         e              = page_mem[slot];
         r.leaf_present = e.present;
         r.perm_out     = e.flags;
         r.frame_out    = e.present ? e.frame : '0;
         if (cmd.command == CMD_TRANSLATE && !e.present) begin
            r.status = STATUS_NOT_MAPPED;
         end
      end
      return r;
   endfunction

   task automatic push_cmd(input logic [CMD_W-1:0] command,
                           input logic [VPN_W-1:0] vpn,
                           input logic [FRAME_W-1:0] ppn,
                           input logic [FLAGS_W-1:0] perm);
      table_cmd_type c;
      c.command   = command;
      c.virt_page = vpn;
      c.phys_page = ppn;
      c.perm_bits = perm;
      pending_cmds.push_back(c);
   endtask

   // Stimulus, reset and the final verdict.
   initial begin
      table_cmd_type    c;
      logic [63:0]      wide;
      int unsigned      pick;
      logic [IDX_W-1:0] leaf;

      reset = 1'b1;
      for (int i = 0; i < 2; i++) begin
         hot_root[i] = IDX_W'($urandom_range(0, ENTRIES-1));
         hot_mid[i]  = IDX_W'($urandom_range(0, ENTRIES-1));
         hot_low[i]  = IDX_W'($urandom_range(0, ENTRIES-1));
      end

      // Directed opening. Every command on an empty table misses at the root.
      push_cmd(CMD_TRANSLATE, '0, '0, '0);
      push_cmd(CMD_GET_PERMS, '1, '1, '1);
      push_cmd(CMD_SET_PERMS, '0, '0, '1);
      push_cmd(CMD_UNMAP,     '0, '0, '0);
      // First map builds all three tables; the neighbor leaf reuses them.
      push_cmd(CMD_MAP,       '0, '1, '1);
      push_cmd(CMD_TRANSLATE, '0, '0, '0);
      push_cmd(CMD_MAP,       36'd1, '0, '0);
      // Absent leaf: translate fails but reports the stored flags, while the
      // flag commands and a second unmap still succeed.
      push_cmd(CMD_UNMAP,     36'd1, '0, '0);
      push_cmd(CMD_TRANSLATE, 36'd1, '0, '0);
      push_cmd(CMD_GET_PERMS, 36'd1, '0, '0);
      push_cmd(CMD_SET_PERMS, 36'd1, '0, 4'b1010);
      push_cmd(CMD_UNMAP,     36'd1, '0, '0);
      push_cmd(CMD_MAP,       36'd1, 40'h12_3456_789a, 4'b0101);
      // Remap of a present leaf overwrites frame and flags.
      push_cmd(CMD_MAP,       '0, 40'h55_5555_5555, 4'b1010);
      push_cmd(CMD_MAP,       '1, 40'haa_aaaa_aaaa, 4'b0101);
      push_cmd(CMD_SET_PERMS, '1, '0, '0);
      push_cmd(CMD_GET_PERMS, '1, '0, '0);
      push_cmd(CMD_TRANSLATE, '1, '0, '0);
      // Shares the root entry of page zero but needs two fresh tables.
      push_cmd(CMD_MAP,       {9'd0, 9'd511, 18'd0}, 40'h00_0000_0001, 4'b1000);
      // Root entry present, second level missing.
      push_cmd(CMD_TRANSLATE, {9'd511, 27'd0}, '0, '0);
      for (int k = 0; k < 3; k++) begin
         push_cmd(CMD_W'(CMD_GET_PERMS + 1 + k), '1, '1, '1);
      end

      // Random part: mostly well-formed traffic on the hot regions, with a
      // little map-heavy noise across the whole address space.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         wide        = {$urandom, $urandom};
         c.phys_page = wide[FRAME_W-1:0];
         c.perm_bits = FLAGS_W'($urandom_range(0, 15));
         if ($urandom_range(0, 99) < 7) begin
            wide        = {$urandom, $urandom};
            c.virt_page = wide[VPN_W-1:0];
            c.command   = $urandom_range(0, 1) ? CMD_MAP : CMD_W'($urandom_range(0, 7));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               c.command = CMD_MAP;
            end else if (pick < 55) begin
               c.command = CMD_TRANSLATE;
            end else if (pick < 65) begin
               c.command = CMD_UNMAP;
            end else if (pick < 80) begin
               c.command = CMD_SET_PERMS;
            end else begin
               c.command = CMD_GET_PERMS;
            end
            // A narrow leaf range makes commands keep hitting the same entries.
            if ($urandom_range(0, 9) < 7) begin
               leaf = IDX_W'($urandom_range(0, 15));
            end else begin
               leaf = IDX_W'($urandom_range(0, ENTRIES-1));
            end
            c.virt_page = {hot_root[$urandom_range(0, 1)], hot_mid[$urandom_range(0, 1)],
                           hot_low[$urandom_range(0, 1)], leaf};
         end
         pending_cmds.push_back(c);
      end
      total_items = pending_cmds.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      wait (accepted_cnt == total_items && expected_results.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("** four_level_page_table_manager_unit: PASSED **");
      end else begin
         $display("** four_level_page_table_manager_unit: FAILED **");
      end
      $finish;
   end

   // Request driver. The expected response is computed at the transfer, so
   // the model sees commands in exactly the order the block accepts them.
   // Valid is assigned once per edge, the payload at most once.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid     <= 1'b0;
         req_if.command   <= '0;
         req_if.virt_page <= '0;
         req_if.phys_page <= '0;
         req_if.perm_bits <= '0;
         accepted_cnt   = 0;
         gap_left       = 0;
         gaps_on        = 1'b1;
         offering       = 1'b0;
         offered        = '0;
         next_free_page = 1;
         for (int i = 0; i < TABLE_PAGES*ENTRIES; i++) begin
            page_mem[i] = '0;
         end
      end else begin
         offering = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            expected_results.push_back(apply_command(offered));
            accepted_cnt = accepted_cnt + 1;
            offering     = 1'b0;
            if (gaps_on && accepted_cnt < total_items - QUIET_TAIL &&
                $urandom_range(0, 2) == 0) begin
               gap_left = $urandom_range(1, 9);
            end
            // Switch gap insertion off now and then for stretches at full rate.
            if (accepted_cnt % 64 == 0) begin
               gaps_on = ($urandom_range(0, 3) != 0);
            end
         end
         if (!offering) begin
            if (gap_left != 0) begin
               gap_left = gap_left - 1;
            end else if (!(accepted_cnt == DRAIN_AT && expected_results.size() != 0) &&
                         pending_cmds.size() != 0) begin
               offered  = pending_cmds.pop_front();
               offering = 1'b1;
               req_if.command   <= offered.command;
               req_if.virt_page <= offered.virt_page;
               req_if.phys_page <= offered.phys_page;
               req_if.perm_bits <= offered.perm_bits;
            end
         end
         req_if.valid <= offering;
      end
   end

   // Response monitor and receiver back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         received_cnt = 0;
         error_count  = 0;
         stall_left   = 0;
         hold_left    = 0;
         stalls_on    = 1'b1;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.status       = rsp_if.status;
            got.frame_out    = rsp_if.frame_out;
            got.perm_out     = rsp_if.perm_out;
            got.leaf_present = rsp_if.leaf_present;
            if (expected_results.size() == 0) begin
               $error("response with no command outstanding: status %0d frame %h",
                      got.status, got.frame_out);
               error_count = error_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got.status != want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  error_count = error_count + 1;
               end
               if (got.frame_out != want.frame_out) begin
                  $error("frame_out: expected %h, got %h", want.frame_out, got.frame_out);
                  error_count = error_count + 1;
               end
               if (got.perm_out != want.perm_out) begin
                  $error("perm_out: expected %h, got %h", want.perm_out, got.perm_out);
                  error_count = error_count + 1;
               end
               if (got.leaf_present != want.leaf_present) begin
                  $error("leaf_present: expected %0d, got %0d",
                         want.leaf_present, got.leaf_present);
                  error_count = error_count + 1;
               end
            end
            received_cnt = received_cnt + 1;
            if (received_cnt == HOLD_AT) begin
               hold_left = HOLD_CYCLES;
            end
            if (received_cnt % 50 == 0) begin
               stalls_on = ($urandom_range(0, 3) != 0);
            end
         end

         if (hold_left != 0) begin
            hold_left  = hold_left - 1;
            ready_next = 1'b0;
         end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            ready_next = 1'b0;
         end else if (stalls_on && received_cnt < total_items - QUIET_TAIL &&
                      $urandom_range(0, 5) == 0) begin
            // This cycle opens a stall burst; stall_left holds the rest of it.
            stall_left = $urandom_range(0, 8);
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_if.ready <= ready_next;
      end
   end

   // Watchdog: ends the run if no transfer happens on either channel for too
   // long. The limit covers the clearing pass after reset several times over.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** four_level_page_table_manager_unit: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// File: sim.f
src/ptm_pkg.sv
src/ptm_req_if.sv
src/ptm_rsp_if.sv
src/four_level_page_table_manager_unit.sv
src/ptm_checker.sv
verif/tb_four_level_page_table_manager_unit.sv
